// ----- rtl/gbpf_pkg.sv -----
// Package for the GCD core: widths, micro-op and condition codes, micro-step
// addresses, the microcode table and the structs passed between sequencer and datapath.
// No dependencies.
`default_nettype none

package gbpf_pkg;

  // Default operand width (the top level overrides through its parameter)
  localparam int unsigned OPERAND_WIDTH_DEF = 16;

  // Micro-step address
  localparam int unsigned UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_IDLE       = 3'd0;
  localparam upc_t UPC_CHK_SMALL  = 3'd1;
  localparam upc_t UPC_HALVE_BOTH = 3'd2;
  localparam upc_t UPC_HALVE_A    = 3'd3;
  localparam upc_t UPC_TEST_B     = 3'd4;
  localparam upc_t UPC_HALVE_B    = 3'd5;
  localparam upc_t UPC_EMIT       = 3'd6;
  localparam upc_t UPC_SUB        = 3'd7;

  // Branch conditions tested by the sequencer
  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_IN_VALID  = 3'd1,
    COND_SMALL     = 3'd2,
    COND_BOTH_EVEN = 3'd3,
    COND_A_EVEN    = 3'd4,
    COND_B_ZERO    = 3'd5,
    COND_B_EVEN    = 3'd6,
    COND_OUT_FREE  = 3'd7
  } cond_t;

  // Datapath operations, carried out only when the step's condition holds
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_LOAD    = 3'd1,
    OP_SET_ONE = 3'd2,
    OP_SHR_AB  = 3'd3,
    OP_SHR_A   = 3'd4,
    OP_SHR_B   = 3'd5,
    OP_SUB     = 3'd6,
    OP_EMIT    = 3'd7
  } op_t;

  // One control word of the microprogram
  typedef struct packed {
    cond_t cond;
    op_t   op;
    upc_t  pc_true;
    upc_t  pc_false;
  } uword_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic below_two;
    logic both_even;
    logic a_even;
    logic b_zero;
    logic b_even;
    logic out_free;
  } dp_status_t;

  // Control from sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic in_ready;
  } dp_ctrl_t;

  // Microprogram: binary (Stein) GCD with an early exit for operands below 2
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    case (pc)
      UPC_IDLE:       w = '{COND_IN_VALID,  OP_LOAD,    UPC_CHK_SMALL,  UPC_IDLE};
      UPC_CHK_SMALL:  w = '{COND_SMALL,     OP_SET_ONE, UPC_EMIT,       UPC_HALVE_BOTH};
      UPC_HALVE_BOTH: w = '{COND_BOTH_EVEN, OP_SHR_AB,  UPC_HALVE_BOTH, UPC_HALVE_A};
      UPC_HALVE_A:    w = '{COND_A_EVEN,    OP_SHR_A,   UPC_HALVE_A,    UPC_TEST_B};
      UPC_TEST_B:     w = '{COND_B_ZERO,    OP_NOP,     UPC_EMIT,       UPC_HALVE_B};
      UPC_HALVE_B:    w = '{COND_B_EVEN,    OP_SHR_B,   UPC_HALVE_B,    UPC_SUB};
      UPC_EMIT:       w = '{COND_OUT_FREE,  OP_EMIT,    UPC_IDLE,       UPC_EMIT};
      UPC_SUB:        w = '{COND_ALWAYS,    OP_SUB,     UPC_TEST_B,     UPC_TEST_B};
      default:        w = '{COND_ALWAYS,    OP_NOP,     UPC_IDLE,       UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gbpf_ifs.sv -----
// Stream interfaces for the GCD core: operand request channel and result channel.
// Depends on gbpf_pkg for the default width.
`default_nettype none

interface gbpf_in_if #(
  parameter int unsigned OPERAND_WIDTH = gbpf_pkg::OPERAND_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] first_value;
  logic [OPERAND_WIDTH-1:0] second_value;

  modport source (output valid, first_value, second_value, input ready);
  modport sink   (input valid, first_value, second_value, output ready);
endinterface

interface gbpf_out_if #(
  parameter int unsigned OPERAND_WIDTH = gbpf_pkg::OPERAND_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] divisor;

  modport source (output valid, divisor, input ready);
  modport sink   (input valid, divisor, output ready);
endinterface

`default_nettype wire

// ----- rtl/gbpf_sequencer.sv -----
// Microcode sequencer: step counter, condition select and branch from the table.
// Depends on gbpf_pkg (microcode table, codes and structs).
`default_nettype none

module gbpf_sequencer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gbpf_pkg::dp_status_t status,
  output gbpf_pkg::dp_ctrl_t       ctrl
);

  gbpf_pkg::upc_t   pc_r;
  gbpf_pkg::upc_t   pc_nxt;
  gbpf_pkg::uword_t uw;
  logic             cond_hit;

  assign uw = gbpf_pkg::ucode(pc_r);

  // condition select
  always_comb begin
    case (uw.cond)
      gbpf_pkg::COND_ALWAYS:    cond_hit = 1'b1;
      gbpf_pkg::COND_IN_VALID:  cond_hit = status.in_valid;
      gbpf_pkg::COND_SMALL:     cond_hit = status.below_two;
      gbpf_pkg::COND_BOTH_EVEN: cond_hit = status.both_even;
      gbpf_pkg::COND_A_EVEN:    cond_hit = status.a_even;
      gbpf_pkg::COND_B_ZERO:    cond_hit = status.b_zero;
      gbpf_pkg::COND_B_EVEN:    cond_hit = status.b_even;
      gbpf_pkg::COND_OUT_FREE:  cond_hit = status.out_free;
      default:                  cond_hit = 1'b0;
    endcase
  end

  // branch and op gating
  always_comb begin
    pc_nxt        = cond_hit ? uw.pc_true : uw.pc_false;
    ctrl.op       = cond_hit ? uw.op : gbpf_pkg::OP_NOP;
    ctrl.in_ready = (pc_r == gbpf_pkg::UPC_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= gbpf_pkg::UPC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gbpf_datapath.sv -----
// Datapath of the GCD core: operand registers, shift count, subtractor and output register.
// Depends on gbpf_pkg (op codes and structs).
`default_nettype none

module gbpf_datapath #(
  parameter int unsigned OPERAND_WIDTH = gbpf_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire gbpf_pkg::dp_ctrl_t       ctrl,
  output gbpf_pkg::dp_status_t          status,
  input  wire logic                     in_valid,
  input  wire logic [OPERAND_WIDTH-1:0] in_first,
  input  wire logic [OPERAND_WIDTH-1:0] in_second,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [OPERAND_WIDTH-1:0]      out_divisor
);

  localparam int unsigned KW = $clog2(OPERAND_WIDTH);

  logic [OPERAND_WIDTH-1:0] a_r, a_nxt;
  logic [OPERAND_WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]            k_r, k_nxt;
  logic [OPERAND_WIDTH-1:0] dout_r, dout_nxt;
  logic                     ovld_r, ovld_nxt;
  logic [OPERAND_WIDTH-1:0] d_ab, d_ba;
  logic                     a_gt_b;

  assign d_ab   = a_r - b_r;
  assign d_ba   = b_r - a_r;
  assign a_gt_b = (a_r > b_r);

  // flags for the sequencer
  always_comb begin
    status.in_valid  = in_valid;
    status.below_two = (a_r[OPERAND_WIDTH-1:1] == '0) || (b_r[OPERAND_WIDTH-1:1] == '0);
    status.both_even = !a_r[0] && !b_r[0];
    status.a_even    = !a_r[0];
    status.b_zero    = (b_r == '0);
    status.b_even    = !b_r[0];
    status.out_free  = !ovld_r || out_ready;
  end

  // operation decode
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    dout_nxt = dout_r;
    ovld_nxt = ovld_r && !out_ready;
    case (ctrl.op)
      gbpf_pkg::OP_NOP: ;
      gbpf_pkg::OP_LOAD: begin
        a_nxt = in_first;
        b_nxt = in_second;
        k_nxt = '0;
      end
      gbpf_pkg::OP_SET_ONE: begin
        a_nxt = OPERAND_WIDTH'(1);
        k_nxt = '0;
      end
      gbpf_pkg::OP_SHR_AB: begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + KW'(1);
      end
      gbpf_pkg::OP_SHR_A: a_nxt = a_r >> 1;
      gbpf_pkg::OP_SHR_B: b_nxt = b_r >> 1;
      gbpf_pkg::OP_SUB: begin
        // keep the smaller value in a, the difference in b
        if (a_gt_b) begin
          a_nxt = b_r;
          b_nxt = d_ab;
        end else begin
          b_nxt = d_ba;
        end
      end
      gbpf_pkg::OP_EMIT: begin
        dout_nxt = a_r << k_r;
        ovld_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    k_r    <= k_nxt;
    dout_r <= dout_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
    end
  end

  assign out_valid   = ovld_r;
  assign out_divisor = dout_r;

endmodule

`default_nettype wire

// ----- rtl/gcd_by_prime_factors_core.sv -----
// Greatest common divisor core.
// Channels: in_if carries a request of two unsigned operands (first_value,
// second_value); out_if returns one divisor per request. Both use valid/ready
// and move an item at a clock edge where both are high.
// An operand of 0 or 1 gives a divisor of 1.
// Operation: one request is worked at a time by a microcoded binary GCD. A
// request with a 0 or 1 operand is accepted, checked and emitted; otherwise it
// is accepted and checked, both operands are halved per common factor of two,
// first_value is halved per further factor of two, and reduction rounds follow,
// each a test of b for zero, the halvings of b and a subtract, until b is zero
// and the result is emitted. out_if.valid rises from the output register after
// the emit step.
// in_if.ready is high only while the sequencer waits for a request.
// Output: the result sits in an output register; the next request is accepted
// and worked while it waits. If the receiver stalls, the next result holds in
// the datapath, with the sequencer at its emit step, until the register is free.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_if.valid; no clearing pass is needed.
// Depends on gbpf_pkg, gbpf_ifs, gbpf_sequencer and gbpf_datapath.
`default_nettype none

module gcd_by_prime_factors_core #(
  parameter int unsigned OPERAND_WIDTH = gbpf_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gbpf_in_if.sink    in_if,
  gbpf_out_if.source out_if
);

  gbpf_pkg::dp_ctrl_t   ctrl;
  gbpf_pkg::dp_status_t status;

  gbpf_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  gbpf_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .status      (status),
    .in_valid    (in_if.valid),
    .in_first    (in_if.first_value),
    .in_second   (in_if.second_value),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_divisor (out_if.divisor)
  );

  assign in_if.ready = ctrl.in_ready;

endmodule

`default_nettype wire

// ----- rtl/gbpf_checker.sv -----
// Port-level checks for the GCD core, attached by bind.
// Depends on gbpf_pkg for the default width and on gcd_by_prime_factors_core.
`default_nettype none

module gbpf_checker #(
  parameter int unsigned OPERAND_WIDTH = gbpf_pkg::OPERAND_WIDTH_DEF
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [OPERAND_WIDTH-1:0] out_divisor
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_divisor))
    else $error("result dropped or changed while stalled");

  // a divisor is never zero
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_divisor != '0)
    else $error("zero divisor delivered");

  // reset leaves the core idle and empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("core not idle after reset");

  // one request at a time: ready drops after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind gcd_by_prime_factors_core gbpf_checker #(
  .OPERAND_WIDTH (OPERAND_WIDTH)
) u_gbpf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_divisor (out_if.divisor)
);

`default_nettype wire
